// ----- rtl/core/tksd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

  typedef logic [7:0] key_byte_t;
  typedef logic [6:0] char_t;

  localparam char_t KeyMask  = 7'h7F;
  localparam char_t KeyEsc   = 7'h1B;
  localparam char_t KeyFs    = 7'h1C;
  localparam char_t KeyCr    = 7'h0D;
  localparam char_t KeySpace = 7'h20;

  // Dense command numbering.
  localparam char_t TkInterrupt   = 7'd0;
  localparam char_t TkLeftWin     = 7'd1;
  localparam char_t TkSetFile     = 7'd2;
  localparam char_t TkBackspace   = 7'd3;
  localparam char_t TkTab         = 7'd4;
  localparam char_t TkReturn      = 7'd5;
  localparam char_t TkChangeWin   = 7'd6;
  localparam char_t TkCtrlQuote   = 7'd7;
  localparam char_t TkRightWin    = 7'd8;
  localparam char_t TkBackTab     = 7'd9;
  localparam char_t TkMoveUp      = 7'd10;
  localparam char_t TkMoveDown    = 7'd11;
  localparam char_t TkMoveLeft    = 7'd12;
  localparam char_t TkMoveRight   = 7'd13;
  localparam char_t TkHome        = 7'd14;
  localparam char_t TkMinusPage   = 7'd15;
  localparam char_t TkMinusLine   = 7'd16;
  localparam char_t TkPlusLine    = 7'd17;
  localparam char_t TkPlusPage    = 7'd18;
  localparam char_t TkTabs        = 7'd19;
  localparam char_t TkUnassigned  = 7'd20;
  localparam char_t TkInsertMode  = 7'd21;
  localparam char_t TkReplace     = 7'd22;
  localparam char_t TkMinusSearch = 7'd23;
  localparam char_t TkPlusSearch  = 7'd24;
  localparam char_t TkClose       = 7'd25;
  localparam char_t TkOpen        = 7'd26;
  localparam char_t TkPick        = 7'd27;
  localparam char_t TkCommand     = 7'd28;
  localparam char_t TkDeleteChar  = 7'd29;
  localparam char_t TkMark        = 7'd30;

  // Sequence tracker, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_ESC    = 4'b0010,
    MODE_FS     = 4'b0100,
    MODE_FS_LET = 4'b1000
  } seq_mode_e;

  localparam char_t FkeyFirst = 7'h35;
  localparam char_t FkeyLast  = 7'h42;
  localparam int    FkeyCount = 14;

  localparam char_t FkeyMap [FkeyCount] = '{
    TkInsertMode, TkSetFile, TkInterrupt, TkReplace, TkUnassigned,
    TkMinusSearch, TkPlusSearch, TkUnassigned, TkClose, TkOpen,
    TkPick, TkCommand, TkDeleteChar, TkMark
  };

  function automatic char_t ctrl_cmd(input logic [4:0] b);
    char_t c;
    case (b)
      5'd3:          c = TkInterrupt;
      5'd5:          c = TkLeftWin;
      5'd7:          c = TkSetFile;
      5'd8, 5'd23:   c = TkBackspace;
      5'd9:          c = TkTab;
      5'd13:         c = TkReturn;
      5'd16:         c = TkChangeWin;
      5'd17:         c = TkCtrlQuote;
      5'd19:         c = TkRightWin;
      5'd20:         c = TkBackTab;
      default:       c = TkUnassigned;
    endcase
    return c;
  endfunction

  function automatic char_t esc_cmd(input char_t b);
    char_t c;
    case (b)
      7'h3B:   c = TkMoveUp;     // ';'
      7'h3C:   c = TkMoveDown;   // '<'
      7'h3E:   c = TkMoveLeft;   // '>'
      7'h3D:   c = TkMoveRight;  // '='
      7'h3F:   c = TkHome;       // '?'
      7'h2E:   c = TkMinusPage;  // '.'
      7'h5C:   c = TkMinusLine;  // backslash
      7'h5B:   c = TkPlusLine;   // '['
      7'h2D:   c = TkPlusPage;   // '-'
      7'h5D:   c = TkTabs;       // ']'
      default: c = TkUnassigned;
    endcase
    return c;
  endfunction

  function automatic char_t fkey_cmd(input char_t letter);
    char_t c;
    char_t ofs;
    ofs = letter - FkeyFirst;
    if (letter inside {[FkeyFirst:FkeyLast]}) begin
      c = FkeyMap[ofs[3:0]];
    end else begin
      c = TkUnassigned;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tksd_key_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tksd_key_if import tksd_pkg::*; ();
  logic      valid;
  logic      ready;
  key_byte_t key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tksd_tok_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tksd_tok_if import tksd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  is_command;
  char_t token_code;

  modport source (output valid, output is_command, output token_code, input ready);
  modport sink   (input valid, input is_command, input token_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/terminal_key_sequence_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keyboard byte stream to editor token decoder. Each request on key_i carries
// one byte (bit 7 ignored); each request on tok_o carries one token, either a
// plain character (is_command = 0) or a command index 0..30. Control bytes map
// to single commands, ESC + byte and FS + letter + CR form multi-byte keys, and
// the bytes that only open or extend such a sequence produce no token. A byte
// is accepted every cycle as long as the token register drains. An accepted
// byte is held in the input register, and its token then goes to the token
// register, which stalls while tok_o is not ready. The sequence-mode register
// and the held FS letter are the only state carried from byte to byte.
module terminal_key_sequence_decoder
  import tksd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tksd_key_if.sink   key_i,
  tksd_tok_if.source tok_o
);

  // Input register.
  logic      in_vld_q;
  char_t     in_byte_q;
  logic      in_adv;

  // Sequence state.
  seq_mode_e mode_q, mode_d;
  char_t     letter_q, letter_d;

  // Decode result.
  logic      emit;
  logic      emit_cmd;
  char_t     emit_code;

  // Token register.
  logic      out_vld_q;
  logic      out_cmd_q;
  char_t     out_code_q;
  logic      out_free;

  assign out_free    = !out_vld_q || tok_o.ready;
  // The decode stage moves on whenever it holds a byte and the token register can take a result.
  assign in_adv      = in_vld_q && out_free;
  assign key_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (key_i.ready) begin
      in_vld_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.ready && key_i.valid) begin
      in_byte_q <= key_i.key_byte[6:0];
    end
  end

  // Decode one byte against the current sequence mode.
  always_comb begin
    mode_d    = mode_q;
    letter_d  = letter_q;
    emit      = 1'b0;
    emit_cmd  = 1'b1;
    emit_code = TkUnassigned;
    case (mode_q)
      MODE_ESC: begin
        mode_d    = MODE_IDLE;
        emit      = 1'b1;
        emit_code = esc_cmd(in_byte_q);
      end
      MODE_FS: begin
        // Hold the letter and wait for CR.
        letter_d = in_byte_q;
        mode_d   = MODE_FS_LET;
      end
      MODE_FS_LET: begin
        // Consume the third byte whatever it is.
        mode_d    = MODE_IDLE;
        emit      = 1'b1;
        emit_code = (in_byte_q == KeyCr) ? fkey_cmd(letter_q) : TkUnassigned;
      end
      default: begin
        if (in_byte_q == KeyEsc) begin
          mode_d = MODE_ESC;
        end else if (in_byte_q == KeyFs) begin
          mode_d = MODE_FS;
        end else if (in_byte_q >= KeySpace) begin
          emit      = 1'b1;
          emit_cmd  = 1'b0;
          emit_code = in_byte_q;
        end else begin
          emit      = 1'b1;
          emit_code = ctrl_cmd(in_byte_q[4:0]);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      letter_q <= '0;
    end else if (in_adv) begin
      mode_q   <= mode_d;
      letter_q <= letter_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && emit) begin
      out_cmd_q  <= emit_cmd;
      out_code_q <= emit_code;
    end
  end

  assign tok_o.valid      = out_vld_q;
  assign tok_o.is_command = out_cmd_q;
  assign tok_o.token_code = out_code_q;

  // A decoded token always lands in the token register.
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && emit) |=> tok_o.valid)
    else $error("decoded token lost");

  // The letter after FS never yields a token.
  a_fs_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && mode_q == MODE_FS) |-> !emit)
    else $error("token emitted on FS letter");

  // After the FS letter the tracker waits for the closing byte.
  a_fs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && mode_q == MODE_FS) |=> (mode_q == MODE_FS_LET && letter_q == $past(in_byte_q)))
    else $error("FS letter not held");

  // No token appears without a byte having been decoded.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tok_o.valid) |-> $past(in_adv && emit))
    else $error("token without source byte");

endmodule

`default_nettype wire
